>>> hw/rtl/assert_macros.svh
// assertion helpers included by matrix_multiply_row_stream.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, switched off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, also held while reset is asserted
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mmrs_pkg.sv
package mmrs_pkg;

	localparam int OUT_ROWS   = 4;
	localparam int INNER_LEN  = 8;
	localparam int OUT_COLS   = 4;
	localparam int ELEM_WIDTH = 8;

	localparam int SUM_W   = 19;
	localparam int PROD_W  = 2 * ELEM_WIDTH;
	localparam int INNER_W = $clog2(INNER_LEN);
	localparam int COL_W   = 2;
	localparam int ROW_W   = 2;
	localparam int IDX_W   = 5;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef struct packed {
		logic                         req_type;
		logic [IDX_W-1:0]             coef_index;
		logic signed [ELEM_WIDTH-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] result_value;
		logic [ROW_W-1:0]        result_row;
		logic [COL_W-1:0]        result_col;
		logic                    last_of_row;
		logic                    last_of_matrix;
	} out_item_t;

	// controls common to every cell of the chain
	typedef struct packed {
		logic mac_en;
		logic row_end;
		logic shift_en;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/mmrs_stream_if.sv
interface mmrs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/matrix_multiply_row_stream.sv
// Streams a 4x8 signed matrix, one element per beat in row-major order, against an
// 8x4 coefficient matrix held in a chain of four column cells; load beats
// (req_type 0) write one coefficient by index, data beats (req_type 1) take one
// element and update all four column sums in the cycle they are accepted. A beat
// is taken whenever req.ready is high, so one item per clock is sustained unless
// a row-closing element is held off. After the eighth element of a row the four
// sums move into the cells' result slots and leave on rsp one beat per cycle while
// rsp is ready, column 0 first, starting the cycle after; the result slots shift
// toward column 0, and a row-closing element is held off only while the previous
// row still has results waiting beyond the head slot, or its head result is
// waiting and rsp is not ready. Load a coefficient before any element that uses it.
`include "assert_macros.svh"

module matrix_multiply_row_stream
	import mmrs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mmrs_stream_if.sink   req,
	mmrs_stream_if.source rsp
);

	logic [INNER_W-1:0]  inner_q;
	logic [ROW_W-1:0]    row_q;
	in_item_t            item;
	logic                row_last;
	logic                can_load;
	logic                acc_data;
	logic                acc_load;
	logic                row_done;
	cell_ctrl_t          ctrl;
	out_item_t           res_chain [OUT_COLS+1];
	logic [OUT_COLS:0]   resv_chain;
	logic [OUT_COLS-1:0] resv_vec;

	assign item     = req.payload;
	assign row_last = (inner_q == INNER_W'(INNER_LEN - 1));
	assign resv_vec = resv_chain[OUT_COLS-1:0];

	// a new row may land once at most the head result is left and it leaves now
	assign can_load  = ((resv_vec >> 1) == '0) && (!resv_vec[0] || rsp.ready);
	assign req.ready = !(item.req_type == REQ_DATA && row_last) || can_load;

	assign acc_data = req.valid && req.ready && (item.req_type == REQ_DATA);
	assign acc_load = req.valid && req.ready && (item.req_type == REQ_LOAD);
	assign row_done = acc_data && row_last;

	assign ctrl.mac_en   = acc_data;
	assign ctrl.row_end  = row_last;
	assign ctrl.shift_en = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			row_q   <= '0;
		end else if (acc_data) begin
			if (row_last) begin
				inner_q <= '0;
				row_q   <= (row_q == ROW_W'(OUT_ROWS - 1)) ? '0 : row_q + 1'b1;
			end else begin
				inner_q <= inner_q + 1'b1;
			end
		end
	end

	assign res_chain[OUT_COLS]  = '0;
	assign resv_chain[OUT_COLS] = 1'b0;

	for (genvar j = 0; j < OUT_COLS; j++) begin : g_cell
		out_item_t meta;

		always_comb begin
			meta                = '0;
			meta.result_row     = row_q;
			meta.result_col     = COL_W'(j);
			meta.last_of_row    = (j == OUT_COLS - 1);
			meta.last_of_matrix = (j == OUT_COLS - 1) && (row_q == ROW_W'(OUT_ROWS - 1));
		end

		mmrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.ld_en    (acc_load && (item.coef_index[COL_W-1:0] == COL_W'(j))),
			.ld_row   (item.coef_index[COL_W +: INNER_W]),
			.elem     (item.value),
			.inner    (inner_q),
			.meta     (meta),
			.res_in   (res_chain[j+1]),
			.resv_in  (resv_chain[j+1]),
			.res_out  (res_chain[j]),
			.resv_out (resv_chain[j])
		);
	end

	assign rsp.valid   = resv_chain[0];
	assign rsp.payload = res_chain[0];

	// pending results always form an unbroken run starting at column 0
	`ASSERT_CLK(a_resv_prefix, clk, arst_n, ((resv_vec + 1'b1) & resv_vec) == '0, "result slots have a gap")
	`ASSERT_CLK(a_row_fill, clk, arst_n, row_done |=> (resv_vec == '1), "row end did not fill all result slots")
	`ASSERT_CLK(a_row_wrap, clk, arst_n, row_done |=> (inner_q == '0), "inner position did not wrap at row end")
	`ASSERT_CLK(a_last_flags, clk, arst_n, (rsp.valid && rsp.payload.last_of_matrix) |-> rsp.payload.last_of_row, "matrix end without row end")

endmodule

>>> hw/rtl/mmrs_cell.sv
module mmrs_cell
	import mmrs_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctrl_t                   ctrl,
	input  logic                         ld_en,
	input  logic [INNER_W-1:0]           ld_row,
	input  logic signed [ELEM_WIDTH-1:0] elem,
	input  logic [INNER_W-1:0]           inner,
	input  out_item_t                    meta,
	input  out_item_t                    res_in,
	input  logic                         resv_in,
	output out_item_t                    res_out,
	output logic                         resv_out
);

	// one coefficient column, indexed by inner position
	logic signed [ELEM_WIDTH-1:0] coef_q [INNER_LEN];
	logic signed [SUM_W-1:0]      acc_q;
	logic signed [PROD_W-1:0]     prod;
	logic signed [SUM_W-1:0]      sum_next;
	out_item_t                    res_q;
	logic                         resv_q;
	out_item_t                    res_d;

	assign prod     = elem * coef_q[inner];
	assign sum_next = acc_q + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

	always_comb begin
		res_d              = meta;
		res_d.result_value = sum_next;
	end

	always_ff @(posedge clk) begin
		if (ld_en) begin
			coef_q[ld_row] <= elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.mac_en) begin
			acc_q <= ctrl.row_end ? '0 : sum_next;
		end
	end

	// result slot: loaded at row end, otherwise shifts toward column 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= 1'b0;
		end else if (ctrl.mac_en && ctrl.row_end) begin
			resv_q <= 1'b1;
		end else if (ctrl.shift_en) begin
			resv_q <= resv_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mac_en && ctrl.row_end) begin
			res_q <= res_d;
		end else if (ctrl.shift_en) begin
			res_q <= res_in;
		end
	end

	assign res_out  = res_q;
	assign resv_out = resv_q;

endmodule

>>> tb/tb.sv
module tb;
	import mmrs_pkg::*;

	typedef struct packed {
		in_item_t                       beat;
		logic                           typed;
		logic [OUT_COLS-1:0][SUM_W-1:0] want;
	} dir_step_t;

	logic clk;
	logic arst_n;

	mmrs_stream_if #(.payload_t(in_item_t))  req_if ();
	mmrs_stream_if #(.payload_t(out_item_t)) rsp_if ();

	matrix_multiply_row_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predictor state
	logic signed [ELEM_WIDTH-1:0] coef_mem [INNER_LEN*OUT_COLS];
	logic signed [SUM_W-1:0]      col_sum [OUT_COLS];
	int                           inner_pos;
	int                           row_pos;
	out_item_t                    row_results_due [$];

	int mismatches;
	bit src_burst;
	bit snk_burst;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#400000;
		$display("matrix_multiply_row_stream: mismatch");
		$finish;
	end

	task automatic report_mismatch(string msg);
		if (mismatches < 50)
			$display("error at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic dir_step_t mk_load(int idx, int val);
		dir_step_t s;
		s = '0;
		s.beat.req_type = REQ_LOAD;
		s.beat.coef_index = idx[IDX_W-1:0];
		s.beat.value = val[ELEM_WIDTH-1:0];
		return s;
	endfunction

	function automatic dir_step_t mk_elem(int idx, int val);
		dir_step_t s;
		s = mk_load(idx, val);
		s.beat.req_type = REQ_DATA;
		return s;
	endfunction

	// row-closing element with the four sums typed in
	function automatic dir_step_t mk_elem_chk(int idx, int val, int w0, int w1, int w2, int w3);
		dir_step_t s;
		s = mk_elem(idx, val);
		s.typed = 1'b1;
		s.want[0] = w0[SUM_W-1:0];
		s.want[1] = w1[SUM_W-1:0];
		s.want[2] = w2[SUM_W-1:0];
		s.want[3] = w3[SUM_W-1:0];
		return s;
	endfunction

	function automatic logic [ELEM_WIDTH-1:0] pick_value();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h00;
			3: return 8'hff;
			default: return ELEM_WIDTH'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic accumulate_beat(in_item_t b);
		out_item_t r;
		if (b.req_type == REQ_LOAD) begin
			coef_mem[b.coef_index] = b.value;
			return;
		end
		for (int j = 0; j < OUT_COLS; j++)
			col_sum[j] = col_sum[j] + b.value * coef_mem[inner_pos*OUT_COLS + j];
		if (inner_pos < INNER_LEN - 1) begin
			inner_pos++;
		end else begin
			for (int j = 0; j < OUT_COLS; j++) begin
				r.result_value = col_sum[j];
				r.result_row = row_pos[ROW_W-1:0];
				r.result_col = j[COL_W-1:0];
				r.last_of_row = (j == OUT_COLS - 1);
				r.last_of_matrix = (j == OUT_COLS - 1) && (row_pos == OUT_ROWS - 1);
				row_results_due.push_back(r);
				col_sum[j] = '0;
			end
			inner_pos = 0;
			row_pos = (row_pos + 1) % OUT_ROWS;
		end
	endtask

	task automatic send_beat(dir_step_t s);
		int gap;
		int n;
		if ($urandom_range(0, 19) == 0)
			src_burst = !src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= s.beat;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		accumulate_beat(s.beat);
		if (s.typed) begin
			n = row_results_due.size();
			for (int j = 0; j < OUT_COLS; j++)
				row_results_due[n - OUT_COLS + j].result_value = s.want[j];
		end
	endtask

	// hold the request side idle until every pending result beat is out
	task automatic drain_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (row_results_due.size() != 0);
	endtask

	initial begin
		dir_step_t dir_steps [$];
		dir_step_t s;

		req_if.valid <= 1'b0;
		req_if.payload <= '0;
		inner_pos = 0;
		row_pos = 0;
		mismatches = 0;
		src_burst = 1'b0;
		foreach (col_sum[j])
			col_sum[j] = '0;

		// every coefficient gets written before any element reads it
		dir_steps = {};
		for (int i = 0; i < INNER_LEN*OUT_COLS; i++)
			dir_steps.push_back(mk_load(i, -128));
		dir_steps = {dir_steps,
			mk_elem(31, -128), mk_elem(0, -128), mk_elem(21, -128), mk_elem(10, -128),
			mk_elem(31, -128), mk_elem(0, -128), mk_elem(21, -128),
			mk_elem_chk(10, -128, 131072, 131072, 131072, 131072),
			mk_elem(5, 127), mk_elem(26, 127), mk_elem(31, 127), mk_elem(0, 127),
			mk_elem(5, 127), mk_elem(26, 127), mk_elem(31, 127),
			mk_elem_chk(0, 127, -130048, -130048, -130048, -130048),
			mk_elem(0, 0), mk_elem(31, 0), mk_elem(0, 0),
			// loads in the middle of a row: one for a later inner position, one for a passed one
			mk_load(31, 127), mk_load(0, 0),
			mk_elem(31, 0), mk_elem(0, 0), mk_elem(31, 0), mk_elem(0, 0),
			mk_elem_chk(0, 1, -128, -128, -128, 127)};

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (dir_steps[i])
			send_beat(dir_steps[i]);
		drain_results();

		for (int i = 0; i < 192; i++) begin
			s = '0;
			s.beat.req_type = ($urandom_range(0, 9) < 2) ? REQ_LOAD : REQ_DATA;
			s.beat.coef_index = IDX_W'($urandom_range(0, 31));
			s.beat.value = pick_value();
			send_beat(s);
			if ($urandom_range(0, 39) == 0)
				drain_results();
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("matrix_multiply_row_stream: match");
		else
			$display("matrix_multiply_row_stream: mismatch");
		$finish;
	end

	initial begin
		out_item_t got;
		out_item_t want;
		int        stall;

		rsp_if.ready <= 1'b0;
		snk_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				snk_burst = !snk_burst;
			stall = snk_burst ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			got = rsp_if.payload;
			if (row_results_due.size() == 0) begin
				report_mismatch($sformatf("result beat with none pending: value %0d row %0d col %0d",
					got.result_value, got.result_row, got.result_col));
			end else begin
				want = row_results_due.pop_front();
				if (got.result_value !== want.result_value)
					report_mismatch($sformatf("result_value %0d, want %0d (row %0d col %0d)",
						got.result_value, want.result_value, want.result_row, want.result_col));
				if (got.result_row !== want.result_row)
					report_mismatch($sformatf("result_row %0d, want %0d",
						got.result_row, want.result_row));
				if (got.result_col !== want.result_col)
					report_mismatch($sformatf("result_col %0d, want %0d",
						got.result_col, want.result_col));
				if (got.last_of_row !== want.last_of_row)
					report_mismatch($sformatf("last_of_row %0b, want %0b (row %0d col %0d)",
						got.last_of_row, want.last_of_row, want.result_row, want.result_col));
				if (got.last_of_matrix !== want.last_of_matrix)
					report_mismatch($sformatf("last_of_matrix %0b, want %0b (row %0d col %0d)",
						got.last_of_matrix, want.last_of_matrix, want.result_row,
						want.result_col));
			end
		end
	end

endmodule
